// ===== hw/rtl/qte_pkg.sv =====
package qte_pkg;

  // Number of CORDIC cells per lane (at most 24 are built); the angle table has 24 entries
  localparam int CORDIC_STAGES = 16;
  localparam int NSTG = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

  localparam int DW   = 16;  // field width
  localparam int PW   = 32;  // product width
  localparam int SW   = 34;  // numerator / denominator width
  localparam int SSW  = 30;  // clamped asin argument width
  localparam int CW   = 37;  // CORDIC vector width
  localparam int ZW   = 33;  // CORDIC angle width, Q.29
  localparam int VW   = 58;  // square root working width
  localparam int SQN  = 29;  // square root cells, one result bit each
  localparam int SQTOP = 56; // first trial bit position
  localparam int IW   = 5;   // cell index width

  localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cord_t;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] res;
  } sq_t;

  function automatic logic signed [ZW-1:0] atan_q29(input logic [IW-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = 33'sd421657428;
      5'd1:    a = 33'sd248918915;
      5'd2:    a = 33'sd131521918;
      5'd3:    a = 33'sd66762579;
      5'd4:    a = 33'sd33510843;
      5'd5:    a = 33'sd16771758;
      5'd6:    a = 33'sd8387925;
      5'd7:    a = 33'sd4194219;
      5'd8:    a = 33'sd2097141;
      5'd9:    a = 33'sd1048575;
      5'd10:   a = 33'sd524288;
      5'd11:   a = 33'sd262144;
      5'd12:   a = 33'sd131072;
      5'd13:   a = 33'sd65536;
      5'd14:   a = 33'sd32768;
      5'd15:   a = 33'sd16384;
      5'd16:   a = 33'sd8192;
      5'd17:   a = 33'sd4096;
      5'd18:   a = 33'sd2048;
      5'd19:   a = 33'sd1024;
      5'd20:   a = 33'sd512;
      5'd21:   a = 33'sd256;
      5'd22:   a = 33'sd128;
      5'd23:   a = 33'sd64;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/qte_if.sv =====
interface qte_in_if;
  import qte_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] q_w;
  logic signed [DW-1:0] q_x;
  logic signed [DW-1:0] q_y;
  logic signed [DW-1:0] q_z;
  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qte_out_if;
  import qte_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] roll;
  logic signed [DW-1:0] pitch;
  logic signed [DW-1:0] yaw;
  logic                 pitch_clamped;
  modport source (output valid, roll, pitch, yaw, pitch_clamped, input ready);
  modport sink (input valid, roll, pitch, yaw, pitch_clamped, output ready);
endinterface

// ===== hw/rtl/quaternion_to_euler.sv =====
// Channel   Dir  Payload                              Handshake
// in_ch     in   q_w q_x q_y q_z (s16 Q2.14)          valid/ready
// out_ch    out  roll pitch yaw (s16 Q3.13), clamp    valid/ready
//
// One item per cycle while the output is not stalled; the stages are
// products, sums, square, 29 square root cells (one result bit each),
// pre-rotation, then one CORDIC cell per iteration, and the output register.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipeline; in_ch.ready is low then.
module quaternion_to_euler
  import qte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  localparam int LPIPE = 4 + SQN + NSTG;
  localparam int DLY   = 2 + SQN + NSTG;

  logic             en;
  logic [LPIPE-1:0] vld_r;
  logic             out_valid_r;

  // Products
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  // Sums
  logic signed [SW-1:0]  rn_r, rd_r, yn_r, yd_r;
  logic signed [SW-1:0]  s_full;
  logic signed [SSW-1:0] s_nxt, s_r;
  logic                  cl_nxt, cl2_r;
  // Square and delay lines
  logic signed [2*SSW-1:0] ss;
  sq_t                     sq0_r;
  logic signed [SW-1:0]    drn_r [0:SQN];
  logic signed [SW-1:0]    drd_r [0:SQN];
  logic signed [SW-1:0]    dyn_r [0:SQN];
  logic signed [SW-1:0]    dyd_r [0:SQN];
  logic signed [SSW-1:0]   ds_r  [0:SQN];
  logic                    cl_r  [0:DLY-1];
  sq_t                     sqo [0:SQN-1];
  // CORDIC lanes: 0 roll, 1 pitch, 2 yaw
  cord_t pre_nxt [0:2];
  cord_t pre_r   [0:2];
  cord_t co      [0:2][0:NSTG-1];
  logic signed [CW-1:0] num [0:2];
  logic signed [CW-1:0] den [0:2];
  logic signed [ZW:0]   zr  [0:2];
  logic signed [DW-1:0] ang [0:2];
  logic signed [DW-1:0] roll_r, pitch_r, yaw_r;
  logic                 clamp_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LPIPE-2:0], in_ch.valid};
      out_valid_r <= vld_r[LPIPE-1];
    end
  end

  // Form products
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_ch.q_w * in_ch.q_x;
      yz_r <= in_ch.q_y * in_ch.q_z;
      xx_r <= in_ch.q_x * in_ch.q_x;
      yy_r <= in_ch.q_y * in_ch.q_y;
      wz_r <= in_ch.q_w * in_ch.q_z;
      xy_r <= in_ch.q_x * in_ch.q_y;
      zz_r <= in_ch.q_z * in_ch.q_z;
      wy_r <= in_ch.q_w * in_ch.q_y;
      zx_r <= in_ch.q_z * in_ch.q_x;
    end
  end

  // Clamp the asin argument to the unit range
  always_comb begin
    s_full = (SW'(wy_r) - SW'(zx_r)) <<< 1;
    cl_nxt = 1'b0;
    if (s_full > ONE_Q28) begin
      s_nxt  = SSW'(ONE_Q28);
      cl_nxt = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      s_nxt  = -SSW'(ONE_Q28);
      cl_nxt = 1'b1;
    end else begin
      s_nxt = SSW'(s_full);
    end
  end

  // Form numerators and denominators
  always_ff @(posedge clk) begin
    if (en) begin
      rn_r  <= (SW'(wx_r) + SW'(yz_r)) <<< 1;
      rd_r  <= ONE_Q28 - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
      yn_r  <= (SW'(wz_r) + SW'(xy_r)) <<< 1;
      yd_r  <= ONE_Q28 - ((SW'(yy_r) + SW'(zz_r)) <<< 1);
      s_r   <= s_nxt;
      cl2_r <= cl_nxt;
    end
  end

  // Square the argument and start the root
  assign ss = s_r * s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r.v   <= (VW'(1) << SQTOP) - VW'(ss);
      sq0_r.res <= '0;
      drn_r[0]  <= rn_r;
      drd_r[0]  <= rd_r;
      dyn_r[0]  <= yn_r;
      dyd_r[0]  <= yd_r;
      ds_r[0]   <= s_r;
      cl_r[0]   <= cl2_r;
    end
  end

  // Hold the other operands beside the root cells
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= SQN; k++) begin
        drn_r[k] <= drn_r[k-1];
        drd_r[k] <= drd_r[k-1];
        dyn_r[k] <= dyn_r[k-1];
        dyd_r[k] <= dyd_r[k-1];
        ds_r[k]  <= ds_r[k-1];
      end
      for (int k = 1; k < DLY; k++) begin
        cl_r[k] <= cl_r[k-1];
      end
    end
  end

  genvar g, l;
  generate
    for (g = 0; g < SQN; g++) begin : g_sq
      qte_sqrt_cell u_cell (
        .clk   (clk),
        .en    (en),
        .idx   (IW'(g)),
        .d_in  ((g == 0) ? sq0_r : sqo[(g == 0) ? 0 : g-1]),
        .d_out (sqo[g])
      );
    end
  endgenerate

  // Turn vectors with negative x by a quarter turn
  always_comb begin
    num[0] = CW'(drn_r[SQN]);
    den[0] = CW'(drd_r[SQN]);
    num[1] = CW'(ds_r[SQN]);
    den[1] = CW'(sqo[SQN-1].res);
    num[2] = CW'(dyn_r[SQN]);
    den[2] = CW'(dyd_r[SQN]);
    for (int n = 0; n < 3; n++) begin
      pre_nxt[n].zero = (num[n] == '0) && (den[n] == '0);
      if (den[n][CW-1]) begin
        if (!num[n][CW-1]) begin
          pre_nxt[n].x = num[n];
          pre_nxt[n].y = -den[n];
          pre_nxt[n].z = HALF_PI_Q29;
        end else begin
          pre_nxt[n].x = -num[n];
          pre_nxt[n].y = den[n];
          pre_nxt[n].z = -HALF_PI_Q29;
        end
      end else begin
        pre_nxt[n].x = den[n];
        pre_nxt[n].y = num[n];
        pre_nxt[n].z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  generate
    for (l = 0; l < 3; l++) begin : g_lane
      for (g = 0; g < NSTG; g++) begin : g_st
        qte_cordic_cell u_cell (
          .clk   (clk),
          .en    (en),
          .idx   (IW'(g)),
          .d_in  ((g == 0) ? pre_r[l] : co[l][(g == 0) ? 0 : g-1]),
          .d_out (co[l][g])
        );
      end
    end
  endgenerate

  // Round the angles to Q3.13
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      zr[n]  = (ZW+1)'(co[n][NSTG-1].z) + (ZW+1)'(32768);
      ang[n] = co[n][NSTG-1].zero ? '0 : zr[n][31:16];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= ang[0];
      pitch_r <= ang[1];
      yaw_r   <= ang[2];
      clamp_r <= cl_r[DLY-1];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.roll          = roll_r;
  assign out_ch.pitch         = pitch_r;
  assign out_ch.yaw           = yaw_r;
  assign out_ch.pitch_clamped = clamp_r;

endmodule

// ===== hw/rtl/qte_sqrt_cell.sv =====
module qte_sqrt_cell
  import qte_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] idx,
  input  sq_t           d_in,
  output sq_t           d_out
);

  logic [5:0]    sh;
  logic [VW-1:0] bitv;
  logic [VW-1:0] trial;
  sq_t           d_nxt;
  sq_t           d_r;

  // Try one result bit: subtract when the remainder allows it
  always_comb begin
    sh    = 6'(SQTOP) - {idx, 1'b0};
    bitv  = VW'(1) << sh;
    trial = d_in.res + bitv;
    if (d_in.v >= trial) begin
      d_nxt.v   = d_in.v - trial;
      d_nxt.res = (d_in.res >> 1) + bitv;
    end else begin
      d_nxt.v   = d_in.v;
      d_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ===== hw/rtl/qte_cordic_cell.sv =====
module qte_cordic_cell
  import qte_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] idx,
  input  cord_t         d_in,
  output cord_t         d_out
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cord_t                d_nxt;
  cord_t                d_r;

  // Rotate towards the x axis and accumulate the angle
  always_comb begin
    xs         = d_in.x >>> idx;
    ys         = d_in.y >>> idx;
    d_nxt.zero = d_in.zero;
    if (!d_in.y[CW-1]) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + atan_q29(idx);
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - atan_q29(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
